>>> design/dbba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Shared types, codes and a helper function for the data block bitmap
// allocator.
// ----------------------------------------------------------------------------
package dbba_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int BLK_W     = 16;
  localparam int CNT_W     = 13;

  typedef enum logic [1:0] {
    MODE_USE,
    MODE_FREE,
    MODE_FIND
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_RANGE,
    STAT_NONE
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN
  } state_t;

  typedef enum logic {
    REG_AREA_BASE,
    REG_AREA_LEN
  } reg_idx_t;

  function automatic logic [CNT_W-1:0] free_calc(input logic [CNT_W-1:0] used,
                                                 input logic [CNT_W-1:0] win);
    logic [CNT_W-1:0] res;
    if (used > win) begin
      res = '0;
    end else begin
      res = win - used;
    end
    return res;
  endfunction

endpackage

>>> design/dbba_map.sv
// ----------------------------------------------------------------------------
// Bitmap allocator usage map
// Usage bitmap held as 64-bit words, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dbba_map #(
  parameter int AW = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [dbba_pkg::WORD_BITS-1:0] wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [dbba_pkg::WORD_BITS-1:0] rd_data
);
  import dbba_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [WORD_BITS-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/dbba_ffz.sv
// ----------------------------------------------------------------------------
// Bitmap allocator free bit encoder
// Priority encoder giving the lowest clear bit of a map word among the bits
// that lie inside the window.
// ----------------------------------------------------------------------------
module dbba_ffz (
  input  logic [dbba_pkg::WORD_BITS-1:0] word,
  input  logic [dbba_pkg::WORD_BITS-1:0] mask,
  output logic                           hit,
  output logic [dbba_pkg::BIT_W-1:0]     pos
);
  import dbba_pkg::*;

  logic [WORD_BITS-1:0] free_bits;

  assign free_bits = ~word & mask;
  assign hit       = |free_bits;

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

endmodule

>>> design/dbba_seq.sv
// ----------------------------------------------------------------------------
// Bitmap allocator sequencer
// Runs the clearing pass, the read-modify-write of a mark and the word by
// word scan for a free block, and keeps the used count and the result beat.
// ----------------------------------------------------------------------------
module dbba_seq #(
  parameter int AW = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode,
  input  logic [dbba_pkg::BLK_W-1:0]     block_number,
  input  logic [dbba_pkg::BLK_W-1:0]     area_base,
  input  logic [dbba_pkg::CNT_W-1:0]     win,
  output logic [AW-1:0]                  rd_addr,
  input  logic [dbba_pkg::WORD_BITS-1:0] rd_data,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [dbba_pkg::WORD_BITS-1:0] wr_data,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [dbba_pkg::BLK_W-1:0]     found_block,
  output logic [dbba_pkg::CNT_W-1:0]     free_count
);
  import dbba_pkg::*;

  state_t               state, state_next;
  logic [AW-1:0]        clr_addr, clr_addr_next;
  logic                 op_set, op_set_next;
  logic [AW-1:0]        op_addr, op_addr_next;
  logic [BIT_W-1:0]     op_bit, op_bit_next;
  logic [AW-1:0]        scan_addr, scan_addr_next;
  logic [AW-1:0]        chk_addr, chk_addr_next;
  logic [CNT_W-1:0]     used_total, used_next;
  logic                 done_next;
  status_t              status_reg, status_next;
  logic [BLK_W-1:0]     found_next;
  logic [CNT_W-1:0]     free_next;

  logic [BLK_W-1:0]     rel;
  logic                 in_win;
  logic [CNT_W-1:0]     win_m1;
  logic [AW-1:0]        last_addr;
  logic [WORD_BITS-1:0] scan_mask;
  logic                 ffz_hit;
  logic [BIT_W-1:0]     ffz_pos;
  logic                 bit_was;
  logic [WORD_BITS-1:0] bit_sel;

  assign rel       = block_number - area_base;
  assign in_win    = (block_number >= area_base) && (rel < BLK_W'(win));
  assign win_m1    = win - CNT_W'(1);
  assign last_addr = AW'(win_m1[CNT_W-1:BIT_W]);
  assign scan_mask = (chk_addr == last_addr) ?
                     ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - win_m1[BIT_W-1:0])) :
                     {WORD_BITS{1'b1}};
  assign bit_sel   = WORD_BITS'(1) << op_bit;
  assign bit_was   = rd_data[op_bit];

  dbba_ffz u_ffz (
    .word (rd_data),
    .mask (scan_mask),
    .hit  (ffz_hit),
    .pos  (ffz_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      used_total <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      used_total <= used_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_set      <= op_set_next;
    op_addr     <= op_addr_next;
    op_bit      <= op_bit_next;
    scan_addr   <= scan_addr_next;
    chk_addr    <= chk_addr_next;
    status_reg  <= status_next;
    found_block <= found_next;
    free_count  <= free_next;
  end

  assign status = status_reg;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    op_set_next    = op_set;
    op_addr_next   = op_addr;
    op_bit_next    = op_bit;
    scan_addr_next = scan_addr;
    chk_addr_next  = chk_addr;
    used_next      = used_total;
    done_next      = 1'b0;
    status_next    = STAT_OK;
    found_next     = '0;
    free_next      = free_calc(used_total, win);
    rd_addr        = scan_addr;
    wr_en          = 1'b0;
    wr_addr        = clr_addr;
    wr_data        = '0;

    case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == {AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          case (mode_t'(mode))
            MODE_USE, MODE_FREE: begin
              if (in_win) begin
                op_set_next  = (mode_t'(mode) == MODE_USE);
                op_addr_next = AW'(rel[BLK_W-1:BIT_W]);
                op_bit_next  = rel[BIT_W-1:0];
                rd_addr      = AW'(rel[BLK_W-1:BIT_W]);
                state_next   = ST_MARK;
              end else begin
                done_next   = 1'b1;
                status_next = STAT_RANGE;
              end
            end
            MODE_FIND: begin
              if (win == '0) begin
                done_next   = 1'b1;
                status_next = STAT_NONE;
              end else begin
                rd_addr        = '0;
                chk_addr_next  = '0;
                scan_addr_next = AW'(1);
                state_next     = ST_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_MARK: begin
        wr_en   = 1'b1;
        wr_addr = op_addr;
        if (op_set) begin
          wr_data = rd_data | bit_sel;
          if (!bit_was) begin
            used_next = used_total + CNT_W'(1);
          end
        end else begin
          wr_data = rd_data & ~bit_sel;
          if (bit_was && (used_total != '0)) begin
            used_next = used_total - CNT_W'(1);
          end
        end
        done_next  = 1'b1;
        free_next  = free_calc(used_next, win);
        state_next = ST_IDLE;
      end

      ST_SCAN: begin
        rd_addr        = scan_addr;
        scan_addr_next = scan_addr + AW'(1);
        chk_addr_next  = scan_addr;
        if (ffz_hit) begin
          done_next   = 1'b1;
          found_next  = area_base + BLK_W'({chk_addr, ffz_pos});
          state_next  = ST_IDLE;
        end else if (chk_addr == last_addr) begin
          done_next   = 1'b1;
          status_next = STAT_NONE;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/data_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Data block bitmap allocator
// Keeps a used/free bit for every block of a data area, marks blocks used or
// free and finds the first free block of the window.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Out-of-window marks
// and unused modes are answered in the cycle after the request; an in-window
// mark reads the map word and writes it back with the bit changed.
// Find first free reads one 64-bit word of the map per cycle through the
// single read port of the map memory. After reset a clearing pass writes
// every map word, one a cycle, with busy high; configuration writes are
// taken during that pass. The result beat is shown for exactly one cycle
// with done high and cannot be held off.
module data_block_bitmap_allocator #(
  parameter int MAP_BITS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [15:0] block_number,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] found_block,
  output logic [12:0] free_count
);
  import dbba_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [16:0] MAP_LIMIT = 17'(MAP_BITS);

  logic [BLK_W-1:0]     area_base;
  logic [CNT_W-1:0]     area_len;
  logic [CNT_W-1:0]     win;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_base <= '0;
      area_len  <= CNT_W'(4096);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_AREA_BASE: area_base <= cfg_data;
        REG_AREA_LEN:  area_len  <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign win = ({4'b0, area_len} > MAP_LIMIT) ? CNT_W'(MAP_LIMIT) : area_len;

  dbba_map #(.AW(AW)) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dbba_seq #(.AW(AW)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .block_number (block_number),
    .area_base    (area_base),
    .win          (win),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .done         (done),
    .status       (status),
    .found_block  (found_block),
    .free_count   (free_count)
  );

endmodule

>>> design/dbba_checker.sv
// ----------------------------------------------------------------------------
// Bitmap allocator port checker
// Checks the request and result beats seen on the allocator's ports.
// ----------------------------------------------------------------------------
module dbba_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [15:0] found_block
);
  import dbba_pkg::*;

  // A taken request either occupies the block or is answered at once.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request taken but neither busy nor answered");

  // No result beat appears without a request having been taken before it.
  assert property (@(posedge clk) disable iff (rst)
    (done && !$past(busy)) |-> $past(start))
    else $error("result beat without a request");

  // Only a successful find reports a block number.
  assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (found_block == '0))
    else $error("block number reported on a failed request");

  assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == STAT_OK) || (status == STAT_RANGE) || (status == STAT_NONE)))
    else $error("undefined status code");

endmodule

bind data_block_bitmap_allocator dbba_checker u_dbba_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .found_block (found_block)
);
